>>> sv/sss_pkg.sv
// Package for the four-digit seven-segment scan driver.
// Holds field widths, character and operation codes, register indexes
// and the constant-divisor digit split. No dependencies.
package sss_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int SEL_W       = 2;
   localparam int CHAR_W      = 4;
   localparam int VALUE_W     = 16;
   localparam int MAG_W       = 14;
   localparam int POS_W       = 3;
   localparam int SLOTS_W     = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int RSP_DATA_W  = 8;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [MAG_W-1:0]  mag_type;

   localparam char_type CODE_BLANK = 4'd10;
   localparam char_type CODE_MINUS = 4'd11;
   localparam char_type CODE_ZERO  = 4'd0;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_POINT_POSITION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_SLOTS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POINT_STEADY   = 2'd2;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sd9999;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = -16'sd999;

   localparam logic [POS_W-1:0]   POINT_POSITION_RESET = 3'd4;
   localparam logic [SLOTS_W-1:0] BLINK_SLOTS_RESET    = 8'd1;

   localparam mag_type UNIT_THOUSANDS = 14'd1000;
   localparam mag_type UNIT_HUNDREDS  = 14'd100;
   localparam mag_type UNIT_TENS      = 14'd10;

   typedef struct packed {
      char_type quot;
      mag_type  rem;
   } split_type;

   // Nine parallel compares against constant multiples of the unit.
   function automatic split_type digit_split(mag_type mag, mag_type unit);
      split_type s;
      s.quot = CODE_ZERO;
      s.rem  = mag;
      for (int k = 1; k <= 9; k++) begin
         if (mag >= MAG_W'(k) * unit) begin
            s.quot = CHAR_W'(k);
            s.rem  = mag - MAG_W'(k) * unit;
         end
      end
      return s;
   endfunction

endpackage

>>> sv/seven_segment_scan_with_blink_point.sv
// A tick beat passes through an input register and then an output register, which
// raises rsp_tvalid; these two registers part the request and response sides.
// Throughput: one beat per cycle, loads and ticks alike, but a tick beat stalls
// while the output register holds a response that rsp_tready has not taken.
// Reset (synchronous, active high): all digits blank, scan at digit 0,
// point at position 4 (none), blink slots 1, point steady and lit.
module seven_segment_scan_with_blink_point (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sss_pkg::VALUE_W-1:0]       req_tdata,   // value
   input  logic                              req_tuser,   // operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sss_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // digit_select, char_code, point_lit
   input  logic                              csr_we,
   input  logic [sss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sss_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                                 in_valid_ff, in_valid_in;
   logic                                 in_op_ff, in_op_in;
   logic signed [sss_pkg::VALUE_W-1:0]   in_value_ff, in_value_in;

   sss_pkg::char_type                    chars_ff [sss_pkg::DIGIT_COUNT];
   sss_pkg::char_type                    chars_in [sss_pkg::DIGIT_COUNT];
   logic [sss_pkg::SEL_W-1:0]            scan_ff, scan_in;
   logic [sss_pkg::SLOTS_W-1:0]          count_ff, count_in;
   logic                                 phase_ff, phase_in;
   logic [sss_pkg::POS_W-1:0]            position_ff, position_in;
   logic [sss_pkg::SLOTS_W-1:0]          slots_ff, slots_in;
   logic                                 steady_ff, steady_in;

   logic                                 out_valid_ff, out_valid_in;
   logic [sss_pkg::RSP_DATA_W-1:0]       out_data_ff, out_data_in;

   logic                                 req_accept;
   logic                                 advance;
   logic                                 tick_go;
   logic                                 load_go;
   logic                                 point_here;
   logic                                 lit;
   logic [sss_pkg::SLOTS_W-1:0]          count_next;
   logic signed [sss_pkg::VALUE_W-1:0]   clamped;
   logic                                 negative;
   sss_pkg::mag_type                     mag;
   sss_pkg::split_type                   split_th;
   sss_pkg::split_type                   split_hu;
   sss_pkg::split_type                   split_te;
   sss_pkg::char_type                    first_char;
   sss_pkg::char_type                    hund_char;

   assign advance    = in_valid_ff && (in_op_ff == sss_pkg::OP_LOAD || !out_valid_ff
                                       || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign tick_go    = advance && in_op_ff == sss_pkg::OP_TICK;
   assign load_go    = advance && in_op_ff == sss_pkg::OP_LOAD;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // value to character codes
   always_comb begin
      priority if (in_value_ff > sss_pkg::VALUE_MAX) begin
         clamped = sss_pkg::VALUE_MAX;
      end else if (in_value_ff < sss_pkg::VALUE_MIN) begin
         clamped = sss_pkg::VALUE_MIN;
      end else begin
         clamped = in_value_ff;
      end
      negative = clamped[sss_pkg::VALUE_W-1];
      mag      = negative ? sss_pkg::MAG_W'(-clamped) : sss_pkg::MAG_W'(clamped);
      split_th = sss_pkg::digit_split(mag, sss_pkg::UNIT_THOUSANDS);
      split_hu = sss_pkg::digit_split(split_th.rem, sss_pkg::UNIT_HUNDREDS);
      split_te = sss_pkg::digit_split(split_hu.rem, sss_pkg::UNIT_TENS);
      if (negative) begin
         first_char = sss_pkg::CODE_MINUS;
      end else if (split_th.quot == sss_pkg::CODE_ZERO) begin
         first_char = sss_pkg::CODE_BLANK;
      end else begin
         first_char = split_th.quot;
      end
      if (split_hu.quot == sss_pkg::CODE_ZERO && first_char != split_th.quot) begin
         hund_char = sss_pkg::CODE_BLANK;
      end else begin
         hund_char = split_hu.quot;
      end
   end

   // scan, blink and configuration
   always_comb begin
      in_valid_in = in_valid_ff;
      in_op_in    = in_op_ff;
      in_value_in = in_value_ff;
      chars_in    = chars_ff;
      scan_in     = scan_ff;
      count_in    = count_ff;
      phase_in    = phase_ff;
      position_in = position_ff;
      slots_in    = slots_ff;
      steady_in   = steady_ff;
      out_data_in = out_data_ff;

      point_here  = {1'b0, scan_ff} == position_ff;
      lit         = point_here && phase_ff;
      count_next  = count_ff + 1'b1;

      if (req_accept) begin
         in_valid_in = 1'b1;
         in_op_in    = req_tuser;
         in_value_in = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (load_go) begin
         chars_in[0] = first_char;
         chars_in[1] = hund_char;
         chars_in[2] = split_te.quot;
         chars_in[3] = sss_pkg::CHAR_W'(split_te.rem);
      end

      if (tick_go) begin
         out_data_in = {1'b0, lit, chars_ff[scan_ff], scan_ff};
         scan_in     = scan_ff + 1'b1;
      end

      if (csr_we) begin
         unique case (csr_index)
            sss_pkg::REG_POINT_POSITION: position_in = csr_wdata[sss_pkg::POS_W-1:0];
            sss_pkg::REG_BLINK_SLOTS:    slots_in    = csr_wdata;
            sss_pkg::REG_POINT_STEADY:   steady_in   = csr_wdata[0];
            default: ;
         endcase
         if (csr_index != sss_pkg::REG_POINT_POSITION && csr_index != sss_pkg::REG_BLINK_SLOTS
             && csr_index != sss_pkg::REG_POINT_STEADY) begin
            count_in = count_ff;
         end else begin
            count_in = '0;
            phase_in = steady_in;
         end
      end else if (tick_go && point_here && !steady_ff) begin
         if (count_next >= slots_ff) begin
            count_in = '0;
            phase_in = !phase_ff;
         end else begin
            count_in = count_next;
         end
      end

      if (tick_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < sss_pkg::DIGIT_COUNT; i++) begin
            chars_ff[i] <= sss_pkg::CODE_BLANK;
         end
         scan_ff      <= '0;
         count_ff     <= '0;
         phase_ff     <= 1'b1;
         position_ff  <= sss_pkg::POINT_POSITION_RESET;
         slots_ff     <= sss_pkg::BLINK_SLOTS_RESET;
         steady_ff    <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         chars_ff     <= chars_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         position_ff  <= position_in;
         slots_ff     <= slots_in;
         steady_ff    <= steady_in;
      end
      in_op_ff    <= in_op_in;
      in_value_ff <= in_value_in;
      out_data_ff <= out_data_in;
   end

endmodule

>>> verif/tb.sv
// Testbench for the four-digit seven-segment scan driver with blinking point.
// Streams loads and scan ticks through a queue-fed driver, checks every slot
// against an in-bench prediction of the digits and point; uses sss_pkg.
module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT = 37;
   localparam int PHASE_ITEMS = 66;
   localparam int DRAIN_CYCLES = 4;
   localparam logic [sss_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct {
      logic                                op;
      logic signed [sss_pkg::VALUE_W-1:0]  value;
   } request_type;

   typedef struct {
      logic [sss_pkg::SEL_W-1:0] sel;
      sss_pkg::char_type         code;
      logic                      lit;
   } slot_type;

   typedef struct {
      int pos;
      int slots;
      int steady;
   } setting_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [sss_pkg::VALUE_W-1:0] req_tdata = '0;
   logic req_tuser = sss_pkg::OP_TICK;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [sss_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [sss_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sss_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   request_type pending_requests[$];
   slot_type    expected_slots[$];

   // predicted block state
   logic [sss_pkg::POS_W-1:0]   point_position;
   logic [sss_pkg::SLOTS_W-1:0] blink_slots;
   logic                        point_steady;
   sss_pkg::char_type           shown_chars[sss_pkg::DIGIT_COUNT];
   logic [sss_pkg::SEL_W-1:0]   scan_index;
   logic [sss_pkg::SLOTS_W-1:0] blink_count;
   logic                        point_phase_on;

   logic smooth_flow = 1'b0;
   int mismatches = 0;
   int cycles = 0;
   int loads_seen = 0;
   int slots_seen = 0;
   int lit_seen = 0;
   int writes_done = 0;

   seven_segment_scan_with_blink_point dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report(string what, int got, int want);
      $display("MISMATCH %s: got %0d, want %0d", what, got, want);
      mismatches++;
   endtask

   function automatic void reset_prediction();
      point_position = sss_pkg::POINT_POSITION_RESET;
      blink_slots    = sss_pkg::BLINK_SLOTS_RESET;
      point_steady   = 1'b1;
      for (int i = 0; i < sss_pkg::DIGIT_COUNT; i++) shown_chars[i] = sss_pkg::CODE_BLANK;
      scan_index     = '0;
      blink_count    = '0;
      point_phase_on = 1'b1;
   endfunction

   function automatic void apply_register(logic [sss_pkg::CSR_IDX_W-1:0] idx,
                                          logic [sss_pkg::CSR_DATA_W-1:0] data);
      unique case (idx)
         sss_pkg::REG_POINT_POSITION: point_position = data[sss_pkg::POS_W-1:0];
         sss_pkg::REG_BLINK_SLOTS:    blink_slots = data[sss_pkg::SLOTS_W-1:0];
         sss_pkg::REG_POINT_STEADY:   point_steady = data[0];
         default:                     return;
      endcase
      blink_count    = '0;
      point_phase_on = point_steady;
   endfunction

   function automatic void load_digits(logic signed [sss_pkg::VALUE_W-1:0] value);
      int n;
      int mag;
      sss_pkg::char_type first;
      sss_pkg::char_type hund;
      n = int'(value);
      if (n > 9999) n = 9999;
      if (n < -999) n = -999;
      if (n < 0) begin
         mag = -n;
         first = sss_pkg::CODE_MINUS;
      end else begin
         mag = n;
         first = sss_pkg::char_type'(mag / 1000);
      end
      mag = mag % 1000;
      hund = sss_pkg::char_type'(mag / 100);
      mag = mag % 100;
      if (first == sss_pkg::CODE_ZERO) first = sss_pkg::CODE_BLANK;
      if (hund == sss_pkg::CODE_ZERO &&
          (first == sss_pkg::CODE_BLANK || first == sss_pkg::CODE_MINUS))
         hund = sss_pkg::CODE_BLANK;
      shown_chars[0] = first;
      shown_chars[1] = hund;
      shown_chars[2] = sss_pkg::char_type'(mag / 10);
      shown_chars[3] = sss_pkg::char_type'(mag % 10);
   endfunction

   function automatic slot_type scan_slot();
      slot_type s;
      s.sel  = scan_index;
      s.code = shown_chars[scan_index];
      s.lit  = 1'b0;
      if ({1'b0, scan_index} == point_position) begin
         s.lit = point_phase_on;
         if (!point_steady) begin
            blink_count = blink_count + 1'b1;
            if (blink_count >= blink_slots) begin
               blink_count = '0;
               point_phase_on = ~point_phase_on;
            end
         end
      end
      scan_index = scan_index + 1'b1;
      return s;
   endfunction

   function automatic int pick_value();
      int corners[12] = '{9999, 10000, -999, -1000, 0, -1, 99, 100, 1000, -100,
                          32767, -32768};
      unique case ($urandom_range(4))
         0: return int'($signed(16'($urandom)));
         1: return corners[$urandom_range(11)];
         2: return -int'($urandom_range(1200));
         default: return int'($urandom_range(10200));
      endcase
   endfunction

   task automatic queue_request(logic op, int value);
      request_type r;
      r.op = op;
      r.value = sss_pkg::VALUE_W'(value);
      pending_requests.push_back(r);
   endtask

   task automatic queue_ticks(int count);
      for (int i = 0; i < count; i++) queue_request(sss_pkg::OP_TICK, 0);
   endtask

   task automatic write_register(logic [sss_pkg::CSR_IDX_W-1:0] idx, int data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= sss_pkg::CSR_DATA_W'(data);
      @(posedge clock);
      apply_register(idx, sss_pkg::CSR_DATA_W'(data));
      writes_done++;
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_slots.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : drive
      request_type next;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser == sss_pkg::OP_LOAD) begin
               load_digits(req_tdata);
               loads_seen++;
            end else begin
               expected_slots.push_back(scan_slot());
            end
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 &&
                (smooth_flow || $urandom_range(99) >= IDLE_PCT)) begin
               next = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next.op;
               req_tdata <= next.value;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : observe
      slot_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            slots_seen++;
            if (expected_slots.size() == 0) begin
               report("slot with none pending", int'(rsp_tdata), 0);
            end else begin
               want = expected_slots.pop_front();
               if (rsp_tdata[1:0] != want.sel)
                  report("digit_select", int'(rsp_tdata[1:0]), int'(want.sel));
               if (rsp_tdata[5:2] != want.code)
                  report("char_code", int'(rsp_tdata[5:2]), int'(want.code));
               if (rsp_tdata[6] != want.lit)
                  report("point_lit", int'(rsp_tdata[6]), int'(want.lit));
               if (want.lit) lit_seen++;
            end
         end
         rsp_tready <= smooth_flow || $urandom_range(99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : run
      setting_type settings[8] = '{
         '{0, 1, 0}, '{3, 0, 0}, '{2, 3, 0}, '{7, 2, 0},
         '{1, 255, 0}, '{0, 2, 1}, '{4, 1, 0}, '{2, 1, 0}
      };
      reset_prediction();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // blank display at reset, then saturation and blanking corners
      queue_ticks(4);
      queue_request(sss_pkg::OP_LOAD, -32768);
      queue_ticks(4);
      queue_request(sss_pkg::OP_LOAD, 32767);
      queue_ticks(4);
      queue_request(sss_pkg::OP_LOAD, -5);
      queue_ticks(4);
      queue_request(sss_pkg::OP_LOAD, 1005);
      queue_ticks(4);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         write_register(sss_pkg::REG_POINT_POSITION, settings[p].pos);
         write_register(sss_pkg::REG_BLINK_SLOTS, settings[p].slots);
         write_register(sss_pkg::REG_POINT_STEADY, settings[p].steady);
         if (p == 3) write_register(REG_UNUSED, int'($urandom_range(255)));
         smooth_flow = (p == 5);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(3) == 0) queue_request(sss_pkg::OP_LOAD, pick_value());
            else queue_request(sss_pkg::OP_TICK, int'($urandom_range(65535)));
         end
         wait_drained();
      end
      smooth_flow = 1'b0;

      $display("Covered %0d loads and %0d scan slots, %0d with the point lit,",
               loads_seen, slots_seen, lit_seen);
      $display("across %0d register writes and eight point settings.", writes_done);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
